@@ hw/rtl/wsd_pkg.sv @@
// Shared types and constants for the WAV stream deframer.
`default_nettype none
package wsd_pkg;

	// Result queue geometry.
	localparam int QDepth = 4;
	localparam int QPtrW  = 2;
	localparam int QCntW  = 3;

	// Result kind codes.
	localparam logic [1:0] KindSample  = 2'd0;
	localparam logic [1:0] KindEnd     = 2'd1;
	localparam logic [1:0] KindInvalid = 2'd2;

	// One input request: a byte of the file with its framing marks.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_file;
		logic       last_of_file;
	} wsd_in_t;

	// One result request.
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic               last_of_run;
	} wsd_out_t;

	// Results produced by one accepted byte, in order.
	typedef struct packed {
		logic [1:0] n;
		wsd_out_t   r0;
		wsd_out_t   r1;
	} wsd_push_t;

	// Queue status seen by the top level.
	typedef struct packed {
		logic [QCntW-1:0] count;
		logic             room;
	} wsd_qstat_t;

endpackage
`default_nettype wire

@@ hw/rtl/wsd_parser.sv @@
// RIFF/WAVE chunk parser: state registers and per-byte next-state logic.
`default_nettype none
module wsd_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire wsd_pkg::wsd_in_t req,
	output wsd_pkg::wsd_push_t    push
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PhIdle, PhRiffTag, PhRiffSize, PhWaveTag,
		PhChunkTag, PhChunkLen, PhSkip, PhData
	} phase_t;

	localparam logic [31:0] TagRiff = 32'h52494646;
	localparam logic [31:0] TagWave = 32'h57415645;
	localparam logic [31:0] TagData = 32'h64617461;

	phase_t      phase_q, ph_e, ph_n;
	logic [1:0]  cnt_q, cnt_e, cnt_n;
	logic [31:0] tag_q, tag_e, tag_n;
	logic [31:0] skip_q, skip_e, skip_n;
	logic [7:0]  low_q, low_e, low_n;
	logic        have_q, have_e, have_n;
	logic        bad, done, sample_v, end_v, to_data;
	logic [31:0] tag_sh, skip_or, skip_dec;
	wsd_out_t    res_sample, res_end;

	// Parser step for the byte on the input.
	always_comb begin
		// A first byte restarts the clip at the RIFF tag.
		ph_e   = req.first_of_file ? PhRiffTag : phase_q;
		cnt_e  = req.first_of_file ? 2'd0 : cnt_q;
		tag_e  = req.first_of_file ? 32'd0 : tag_q;
		skip_e = req.first_of_file ? 32'd0 : skip_q;
		low_e  = req.first_of_file ? 8'd0 : low_q;
		have_e = req.first_of_file ? 1'b0 : have_q;

		ph_n     = ph_e;
		cnt_n    = cnt_e;
		tag_n    = tag_e;
		skip_n   = skip_e;
		low_n    = low_e;
		have_n   = have_e;
		bad      = 1'b0;
		sample_v = 1'b0;
		done     = (cnt_e == 2'd3);
		tag_sh   = {tag_e[23:0], req.data_byte};
		skip_or  = skip_e | ({24'd0, req.data_byte} << {cnt_e, 3'b000});
		skip_dec = skip_e - 32'd1;

		unique case (ph_e)
			PhIdle: begin
			end
			PhRiffTag, PhWaveTag, PhChunkTag: begin
				tag_n = tag_sh;
				cnt_n = cnt_e + 2'd1;
				if (done) begin
					if (ph_e == PhChunkTag) begin
						ph_n   = PhChunkLen;
						skip_n = 32'd0;
					end else if ((ph_e == PhRiffTag && tag_sh == TagRiff) ||
					             (ph_e == PhWaveTag && tag_sh == TagWave)) begin
						ph_n   = (ph_e == PhRiffTag) ? PhRiffSize : PhChunkTag;
						tag_n  = 32'd0;
						skip_n = 32'd0;
					end else begin
						bad = 1'b1;
					end
				end
			end
			PhRiffSize: begin
				cnt_n = cnt_e + 2'd1;
				if (done) begin
					ph_n   = PhWaveTag;
					tag_n  = 32'd0;
					skip_n = 32'd0;
				end
			end
			PhChunkLen: begin
				skip_n = skip_or;
				cnt_n  = cnt_e + 2'd1;
				if (done) begin
					if (tag_e == TagData) begin
						ph_n   = PhData;
						have_n = 1'b0;
					end else if (skip_or == 32'd0) begin
						ph_n  = PhChunkTag;
						tag_n = 32'd0;
					end else begin
						ph_n = PhSkip;
					end
				end
			end
			PhSkip: begin
				skip_n = skip_dec;
				if (skip_dec == 32'd0) begin
					ph_n  = PhChunkTag;
					cnt_n = 2'd0;
					tag_n = 32'd0;
				end
			end
			PhData: begin
				if (have_e) begin
					sample_v = 1'b1;
					have_n   = 1'b0;
				end else begin
					low_n  = req.data_byte;
					have_n = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// The end of a file is clean only once this byte leaves the parser in data.
		to_data = (ph_n == PhData);

		// A bad tag or the end of the file closes the clip.
		end_v = bad || (req.last_of_file && ph_e != PhIdle);
		if (end_v) begin
			ph_n   = PhIdle;
			cnt_n  = 2'd0;
			tag_n  = 32'd0;
			skip_n = 32'd0;
			low_n  = 8'd0;
			have_n = 1'b0;
		end
	end

	// Result words for this byte.
	always_comb begin
		res_sample.kind         = KindSample;
		res_sample.left_sample  = {req.data_byte, low_e};
		res_sample.right_sample = {req.data_byte, low_e};
		res_sample.last_of_run  = !end_v;
		res_end.kind            = (!bad && to_data) ? KindEnd : KindInvalid;
		res_end.left_sample     = 16'sd0;
		res_end.right_sample    = 16'sd0;
		res_end.last_of_run     = 1'b1;

		push = '0;
		if (sample_v && end_v) begin
			push.n  = 2'd2;
			push.r0 = res_sample;
			push.r1 = res_end;
		end else if (sample_v) begin
			push.n  = 2'd1;
			push.r0 = res_sample;
		end else if (end_v) begin
			push.n  = 2'd1;
			push.r0 = res_end;
		end
	end

	// Parser state, advanced once per accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhIdle;
			cnt_q   <= 2'd0;
			tag_q   <= 32'd0;
			skip_q  <= 32'd0;
			low_q   <= 8'd0;
			have_q  <= 1'b0;
		end else if (take) begin
			phase_q <= ph_n;
			cnt_q   <= cnt_n;
			tag_q   <= tag_n;
			skip_q  <= skip_n;
			low_q   <= low_n;
			have_q  <= have_n;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/wsd_outq.sv @@
// Result queue: takes up to two results per cycle, gives out one per ready cycle.
`default_nettype none
module wsd_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire wsd_pkg::wsd_push_t push,
	output wsd_pkg::wsd_out_t      result,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output wsd_pkg::wsd_qstat_t    stat
);
	import wsd_pkg::*;

	wsd_out_t         entry_q [QDepth];
	logic [QPtrW-1:0] wr_q, rd_q;
	logic [QCntW-1:0] count_q, add, sub;
	logic             pop;

	assign pop          = result_valid && result_ready;
	assign result_valid = (count_q != '0);
	assign result       = entry_q[rd_q];
	assign add          = take ? QCntW'(push.n) : '0;
	assign sub          = pop ? QCntW'(1) : '0;
	assign stat.count   = count_q;
	assign stat.room    = (count_q <= QCntW'(QDepth - 2));

	// Entry storage: results written at the tail.
	always_ff @(posedge clk) begin
		if (take && push.n != 2'd0) begin
			entry_q[wr_q] <= push.r0;
		end
		if (take && push.n == 2'd2) begin
			entry_q[wr_q + QPtrW'(1)] <= push.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPtrW'(add);
			rd_q    <= rd_q + QPtrW'(sub);
			count_q <= count_q + add - sub;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/wav_stream_deframer.sv @@
// Top level of the WAV stream deframer.
`default_nettype none
// Takes a WAV file one byte per request and gives out PCM samples (one value
// on both channels), a clean-end marker or an invalid-file marker. A byte can
// be accepted in every cycle: byte_ready is high while the four-entry result
// queue has two free entries, and its results are queued for the result port
// from the next cycle. Results leave at one per cycle; a byte that ends a clip
// during data can give two results, so a stalled result port holds off further
// bytes once the queue fills. first_of_file restarts the parser at any time.
module wav_stream_deframer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             byte_valid,
	output logic                  byte_ready,
	input  wire wsd_pkg::wsd_in_t byte_req,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output wsd_pkg::wsd_out_t     result
);
	import wsd_pkg::*;

	wsd_push_t  push;
	wsd_qstat_t stat;
	logic       take;

	// A byte is taken while the queue can hold both of its possible results.
	assign byte_ready = stat.room;
	assign take       = byte_valid && byte_ready;

	wsd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (byte_req),
		.push   (push)
	);

	wsd_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.push         (push),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat)
	);

`ifndef SYNTHESIS
	// The queue never overfills.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= QCntW'(QDepth))
		else $error("result queue overfilled");

	// A taken byte always found room for its results.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> stat.count <= QCntW'(QDepth - 2))
		else $error("byte taken without room");

	// A pair of results is a sample followed by the closing marker.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(take && push.n == 2'd2) |->
		(push.r0.kind == KindSample && !push.r0.last_of_run && push.r1.last_of_run))
		else $error("bad result pair");

	// A taken byte with results makes the result port valid next cycle.
	a_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(take && push.n != 2'd0) |=> result_valid)
		else $error("result lost");
`endif

endmodule
`default_nettype wire
